[rtl/wsbl_pkg.sv]
package wsbl_pkg;

    // Fixed field widths of one word.
    localparam int LenW   = 3;
    localparam int CharsW = 56;
    localparam int CharB  = CharsW / 8;

    // Word request as it arrives.
    typedef struct packed {
        logic [LenW-1:0]   word_length;
        logic [CharsW-1:0] word_chars;
        logic              last_word;
    } word_req_t;

    // Sorted result as it leaves.
    typedef struct packed {
        logic [LenW-1:0]   sorted_length;
        logic [CharsW-1:0] sorted_chars;
        logic              last_result;
        logic              overflowed;
    } sorted_req_t;

    // One stored record.
    typedef struct packed {
        logic [LenW-1:0]   len;
        logic [CharsW-1:0] chars;
    } rec_t;

    // Contents of one cell as seen by its neighbors.
    typedef struct packed {
        logic valid;
        rec_t rec;
    } slot_t;

    // Command broadcast to every cell.
    typedef struct packed {
        logic insert;
        logic drain;
        rec_t new_rec;
    } cell_ctl_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_LOAD  = 2'b01,
        ST_DRAIN = 2'b10
    } state_t;

endpackage

[rtl/word_sort_by_length_top.sv]
// Stable sort of short words by length. Words are taken one per cycle, while
// word_stall is low, into a row of MAX_WORDS insertion cells, which keep them
// ordered by length as they arrive (equal lengths stay in arrival order). The
// request marked last_word starts the output: the row then shifts toward its
// head and one sorted word leaves per cycle unless sorted_stall holds back a
// waiting result. word_stall stays high until the row is empty and the
// sequencer has returned to loading.
// Words that arrive while the row is full are dropped and every result of that
// run carries overflowed. Lengths above MAX_CHARS saturate, and character bytes
// at and above the length are cleared.
module word_sort_by_length_top #(
    parameter int MAX_WORDS = 64,
    parameter int MAX_CHARS = 7
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  word_valid,
    output logic                  word_stall,
    input  wsbl_pkg::word_req_t   word_data,
    output logic                  sorted_valid,
    input  logic                  sorted_stall,
    output wsbl_pkg::sorted_req_t sorted_data
);
    import wsbl_pkg::*;

    localparam int CntW = $clog2(MAX_WORDS + 1);
    localparam logic [CntW-1:0] MaxCnt  = CntW'(MAX_WORDS);
    localparam logic [LenW:0]   MaxChrs = (LenW + 1)'(MAX_CHARS);

    state_t            state_reg;
    state_t            state_next;
    logic [CntW-1:0]   count_reg;
    logic [CntW-1:0]   count_next;
    logic              ovf_reg;
    logic              ovf_next;
    logic              out_valid_reg;
    logic              out_valid_next;
    sorted_req_t       out_reg;
    sorted_req_t       out_next;

    logic              accept;
    logic              can_load;
    logic [LenW-1:0]   len_sat;
    logic [CharsW-1:0] chars_kept;
    cell_ctl_t         ctl;
    slot_t             slots [MAX_WORDS];
    logic              gts   [MAX_WORDS];

    assign word_stall = (state_reg != ST_LOAD);
    assign accept     = word_valid && !word_stall;
    assign can_load   = !out_valid_reg || !sorted_stall;

    // Saturate the length and clear bytes at and above it.
    always_comb
    begin
        if ({1'b0, word_data.word_length} > MaxChrs)
        begin
            len_sat = MaxChrs[LenW-1:0];
        end
        else
        begin
            len_sat = word_data.word_length;
        end
        for (int b = 0; b < CharB; b++)
        begin
            if (b < int'(len_sat))
            begin
                chars_kept[b*8 +: 8] = word_data.word_chars[b*8 +: 8];
            end
            else
            begin
                chars_kept[b*8 +: 8] = 8'h00;
            end
        end
    end

    // Command broadcast to the cells.
    always_comb
    begin
        ctl.insert        = accept && (count_reg < MaxCnt);
        ctl.drain         = (state_reg == ST_DRAIN) && slots[0].valid && can_load;
        ctl.new_rec.len   = len_sat;
        ctl.new_rec.chars = chars_kept;
    end

    // Row of insertion cells.
    for (genvar i = 0; i < MAX_WORDS; i++)
    begin : g_cell
        slot_t left_s;
        slot_t right_s;
        logic  left_g;

        if (i == 0)
        begin : g_head
            assign left_s = '0;
            assign left_g = 1'b0;
        end
        else
        begin : g_body
            assign left_s = slots[i-1];
            assign left_g = gts[i-1];
        end

        if (i == MAX_WORDS - 1)
        begin : g_tail
            assign right_s = '0;
        end
        else
        begin : g_mid
            assign right_s = slots[i+1];
        end

        wsbl_cell u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .left    (left_s),
            .left_gt (left_g),
            .right   (right_s),
            .slot    (slots[i]),
            .gt      (gts[i])
        );
    end

    // Sequencer, fill count, overflow flag and output register.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && sorted_stall;
        out_next       = out_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    if (count_reg < MaxCnt)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (word_data.last_word)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!slots[0].valid)
                begin
                    state_next = ST_LOAD;
                    count_next = '0;
                    ovf_next   = 1'b0;
                end
                else if (can_load)
                begin
                    out_valid_next            = 1'b1;
                    out_next.sorted_length    = slots[0].rec.len;
                    out_next.sorted_chars     = slots[0].rec.chars;
                    out_next.last_result      = !slots[1].valid;
                    out_next.overflowed       = ovf_reg;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign sorted_valid = out_valid_reg;
    assign sorted_data  = out_reg;

endmodule

[rtl/wsbl_cell.sv]
module wsbl_cell (
    input  logic               clk,
    input  logic               rst_n,
    input  wsbl_pkg::cell_ctl_t ctl,
    input  wsbl_pkg::slot_t    left,
    input  logic               left_gt,
    input  wsbl_pkg::slot_t    right,
    output wsbl_pkg::slot_t    slot,
    output logic               gt
);
    import wsbl_pkg::*;

    logic valid_reg;
    logic valid_next;
    rec_t rec_reg;
    rec_t rec_next;

    // The new word goes behind every stored word of equal or smaller length,
    // which keeps words of equal length in arrival order.
    assign gt = !valid_reg || (rec_reg.len > ctl.new_rec.len);

    // Insert shifts the tail right and drops the new word into the gap;
    // drain shifts everything left toward the head cell.
    always_comb
    begin
        valid_next = valid_reg;
        rec_next   = rec_reg;
        if (ctl.insert && gt)
        begin
            if (left_gt)
            begin
                valid_next = left.valid;
                rec_next   = left.rec;
            end
            else
            begin
                valid_next = 1'b1;
                rec_next   = ctl.new_rec;
            end
        end
        else if (ctl.drain)
        begin
            valid_next = right.valid;
            rec_next   = right.rec;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign slot.valid = valid_reg;
    assign slot.rec   = rec_reg;

endmodule
